FILE: sv/piecewise_linear_envelope_top_macros.svh
// ----------------------------------------------------------------------------
// piecewise_linear_envelope_top_macros
// assertion macros shared by the envelope checker
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_ENVELOPE_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_ENVELOPE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PWLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PWLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pwle_pkg.sv
// ----------------------------------------------------------------------------
// pwle_pkg
// types and constants of the piecewise linear envelope generator
// ----------------------------------------------------------------------------
package pwle_pkg;

  // table size and derived widths
  localparam int MAX_POINTS = 16;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = 16 + PT_W;
  localparam int DIV_STEPS  = 16;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // input transaction
  typedef struct packed {
    logic        cmd;
    logic [3:0]  point_index;
    logic [15:0] level;
    logic [15:0] duration;
    logic [15:0] tick;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [15:0] envelope_level;
    logic        past_end;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [15:0] level;
    logic [15:0] duration;
  } point_t;

endpackage

FILE: sv/piecewise_linear_envelope_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_envelope_top
// piecewise linear envelope generator with a point table in block memory
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_stall_o, in_data_i): a load transaction
//   (cmd 0) writes level and duration of one point into the table and gives
//   no result; an evaluate transaction (cmd 1) gives one result on the out
//   channel (out_valid_o / out_stall_i, out_data_o).
//   cfg channel (cfg_valid_i / cfg_ready_o, cfg_data_i) writes point_count;
//   it is always ready. The user must see that it is written only while the
//   block is idle; the block itself does not enforce this. An evaluate walks
//   the n points in use (1..16) through the single read port of the table,
//   then multiplies, adds the rounding bias, and a restoring divider retires
//   one quotient bit a cycle until all 16 bits are done. A tick past the end
//   skips the arithmetic. The block takes no new transaction until the result
//   of an evaluate is in the output register; a load does not hold the in
//   channel.
//   A stalled result waits in the output register while the block accepts
//   the next transaction; a second result is held until the first is taken.
//   Reset clears point_count to 1 and the control state; the point table is
//   not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module piecewise_linear_envelope_top
  import pwle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_MUL  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]       count_q;
  logic [CNT_W-1:0] n_use;
  logic [CNT_W-1:0] n_q;

  // point table and its registered read port
  point_t           mem_q [MAX_POINTS];
  point_t           rdata_q;
  logic [PT_W-1:0]  rd_addr;
  logic             wr_en;

  // walk registers
  logic [PT_W-1:0]  chk_q;
  logic [SUM_W-1:0] start_q;
  logic [15:0]      tick_q;
  logic             found_q;
  logic             need_next_q;
  logic             wrap_q;
  logic [15:0]      lvl0_q;
  logic [15:0]      lvl_a_q;
  logic [15:0]      lvl_b_q;
  logic [15:0]      dur_q;
  logic [15:0]      off_q;

  // arithmetic registers
  logic             up_q;
  logic [31:0]      prod_q;
  logic [16:0]      rem_q;
  logic [15:0]      quo_q;
  logic [STEP_W-1:0] step_q;

  // output register
  logic             out_valid_q;
  out_item_t        out_q;

  logic             in_acc;
  logic             out_free;
  logic             last_chk;
  logic             hit;
  logic [SUM_W-1:0] seg_end;
  logic [SUM_W-1:0] tick_ext;
  logic [15:0]      lvl_b;
  logic [31:0]      num;
  logic [16:0]      trial;
  logic             trial_ge;
  logic [15:0]      interp;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // points in use: zero reads as one, saturate at table size
  always_comb begin
    if (count_q == 5'd0) begin
      n_use = CNT_W'(1);
    end else if (32'(count_q) > MAX_POINTS) begin
      n_use = CNT_W'(MAX_POINTS);
    end else begin
      n_use = CNT_W'(count_q);
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // table write and read port
  assign wr_en   = in_acc && (in_data_i.cmd == CMD_LOAD) &&
                   (32'(in_data_i.point_index) < MAX_POINTS);
  assign rd_addr = (state_q == S_WALK) ? chk_q + PT_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[PT_W'(in_data_i.point_index)] <= '{level: in_data_i.level,
                                               duration: in_data_i.duration};
    end
    rdata_q <= mem_q[rd_addr];
  end

  // segment search on the entry that the read port returns
  assign tick_ext = SUM_W'(tick_q);
  assign seg_end  = start_q + SUM_W'(rdata_q.duration);
  assign hit      = !found_q && (rdata_q.duration != 16'd0) && (tick_ext < seg_end);
  assign last_chk = (CNT_W'(chk_q) == n_q - CNT_W'(1));

  // far point of the segment, with the wrap back to point zero
  assign lvl_b = wrap_q ? lvl0_q : lvl_b_q;

  // numerator with the ceiling bias on a falling segment
  assign num = prod_q + (up_q ? 32'd0 : 32'(dur_q) - 32'd1);

  // one restoring division step
  assign trial    = {rem_q[15:0], quo_q[15]};
  assign trial_ge = (trial >= 17'(dur_q));

  assign interp = up_q ? lvl_a_q + quo_q : lvl_a_q - quo_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && (in_data_i.cmd == CMD_EVAL)) state_d = S_WALK;
      S_WALK: if (last_chk) state_d = S_MUL;
      S_MUL:  state_d = found_q ? S_PREP : S_OUT;
      S_PREP: state_d = S_DIV;
      S_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walk and arithmetic datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      need_next_q <= 1'b0;
      chk_q       <= '0;
      step_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && (in_data_i.cmd == CMD_EVAL)) begin
            found_q     <= 1'b0;
            need_next_q <= 1'b0;
            wrap_q      <= 1'b0;
            chk_q       <= '0;
            start_q     <= '0;
            tick_q      <= in_data_i.tick;
            n_q         <= n_use;
          end
        end
        S_WALK: begin
          if (chk_q == '0) begin
            lvl0_q <= rdata_q.level;
          end
          if (need_next_q) begin
            lvl_b_q     <= rdata_q.level;
            need_next_q <= 1'b0;
          end
          if (hit) begin
            found_q     <= 1'b1;
            need_next_q <= 1'b1;
            wrap_q      <= last_chk;
            lvl_a_q     <= rdata_q.level;
            dur_q       <= rdata_q.duration;
            off_q       <= 16'(tick_ext - start_q);
          end
          start_q <= seg_end;
          chk_q   <= chk_q + PT_W'(1);
        end
        S_MUL: begin
          up_q   <= (lvl_b >= lvl_a_q);
          prod_q <= 32'((lvl_b >= lvl_a_q) ? lvl_b - lvl_a_q : lvl_a_q - lvl_b) *
                    32'(off_q);
        end
        S_PREP: begin
          rem_q  <= {1'b0, num[31:16]};
          quo_q  <= num[15:0];
          step_q <= '0;
        end
        S_DIV: begin
          rem_q  <= trial_ge ? trial - 17'(dur_q) : trial;
          quo_q  <= {quo_q[14:0], trial_ge};
          step_q <= step_q + STEP_W'(1);
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_q.envelope_level <= found_q ? interp : lvl0_q;
      out_q.past_end       <= !found_q;
    end
  end

endmodule

FILE: sv/pwle_checker.sv
// ----------------------------------------------------------------------------
// pwle_checker
// port-level checks of the envelope generator, bound to the top level
// ----------------------------------------------------------------------------
`include "piecewise_linear_envelope_top_macros.svh"

module pwle_port_checker
  import pwle_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o
);

  // accepted input transactions by kind
  logic eval_acc;
  logic load_acc;

  assign eval_acc = in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_EVAL);
  assign load_acc = in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_LOAD);

  // a stalled result holds its value
  `PWLE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled result changed")

  // an evaluate transaction makes the block busy
  `PWLE_ASSERT_NEXT(a_eval_busy, eval_acc, in_stall_o, "evaluate did not occupy the block")

  // a load transaction does not make the block busy
  `PWLE_ASSERT_NEXT(a_load_free, load_acc, !in_stall_o, "load held the input channel")

  // a new result appears only at the end of an evaluate
  `PWLE_ASSERT_IMP(a_out_from_eval, $rose(out_valid_o), $past(in_stall_o),
                   "result without an evaluate in flight")

  // the configuration channel never refuses a write
  `PWLE_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o, "configuration write refused")

endmodule

bind piecewise_linear_envelope_top pwle_port_checker u_pwle_port_checker (.*);

FILE: sim/pwle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwle_checker
// watches the in, out and cfg channels of the envelope generator, keeps its
// own copy of the point table and point count, works out the level each
// evaluate transaction must return and compares every result in order
// ----------------------------------------------------------------------------
module pwle_checker
  import pwle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [4:0] cfg_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_o,
  output int        past_end_o
);

  // shadow of the point table and the point count register
  point_t     envelope_points [MAX_POINTS];
  logic [4:0] point_count_q;

  // results still owed by the block, oldest first
  out_item_t  expected_envelope_q [$];

  int fails;
  int results_seen;
  int past_end_seen;

  // level and past-end flag the block must give for one tick
  function automatic out_item_t envelope_at(input logic [15:0] tick);
    int unsigned     n;
    int unsigned     total;
    int unsigned     start;
    int unsigned     d;
    int unsigned     off;
    int unsigned     nxt;
    logic [15:0]     a;
    logic [15:0]     b;
    longint unsigned q;
    bit              hit;
    out_item_t       r;
    n = point_count_q;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    total = 0;
    for (int i = 0; i < n; i++) total += envelope_points[i].duration;
    r.envelope_level = envelope_points[0].level;
    r.past_end       = (tick >= total);
    if (!r.past_end) begin
      start = 0;
      hit   = 1'b0;
      for (int i = 0; i < n && !hit; i++) begin
        d = envelope_points[i].duration;
        if (d != 0 && tick >= start && tick < start + d) begin
          nxt = (i + 1 < n) ? i + 1 : 0;
          a   = envelope_points[i].level;
          b   = envelope_points[nxt].level;
          off = tick - start;
          // rising segments round down, falling ones round the drop up
          if (b >= a) begin
            q = ((64'(b) - 64'(a)) * off) / d;
            r.envelope_level = a + q[15:0];
          end else begin
            q = ((64'(a) - 64'(b)) * off + d - 1) / d;
            r.envelope_level = a - q[15:0];
          end
          hit = 1'b1;
        end
        start += d;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  // track transactions on all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      point_count_q = 5'd1;
      expected_envelope_q.delete();
    end else begin
      // result side first: a result never belongs to a same-edge request
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (out_data_i.past_end === 1'b1) past_end_seen++;
        if (expected_envelope_q.size() == 0) begin
          report_mismatch($sformatf("result level %0d past_end %0b with none expected",
                                    out_data_i.envelope_level, out_data_i.past_end));
        end else begin
          exp_item = expected_envelope_q.pop_front();
          if (out_data_i.envelope_level !== exp_item.envelope_level)
            report_mismatch($sformatf("envelope_level %0d, expected %0d",
                                      out_data_i.envelope_level,
                                      exp_item.envelope_level));
          if (out_data_i.past_end !== exp_item.past_end)
            report_mismatch($sformatf("past_end %0b, expected %0b",
                                      out_data_i.past_end, exp_item.past_end));
        end
      end
      // point count write
      if (cfg_valid_i && cfg_ready_i) point_count_q = cfg_data_i;
      // load updates the table, evaluate owes one result
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.cmd == CMD_LOAD) begin
          if (int'(in_data_i.point_index) < MAX_POINTS) begin
            envelope_points[in_data_i.point_index].level    = in_data_i.level;
            envelope_points[in_data_i.point_index].duration = in_data_i.duration;
          end
        end else begin
          expected_envelope_q.push_back(envelope_at(in_data_i.tick));
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = expected_envelope_q.size();
  assign results_o    = results_seen;
  assign past_end_o   = past_end_seen;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the piecewise linear envelope generator: directed loads and
// evaluates over the table edges, then random phases under several point
// counts with random idling on both channels; a checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
  import pwle_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 110;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i  = '0;

  int fail_count;
  int pending;
  int results;
  int past_ends;

  // stimulus bookkeeping, used only to steer ticks into the envelope
  logic [15:0] shadow_dur [MAX_POINTS];
  logic [4:0]  cur_count = 5'd1;
  bit          steady    = 1'b0;
  int          load_count;
  int          eval_count;
  int          settings_count;
  int          cycle_count;

  piecewise_linear_envelope_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  pwle_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .past_end_o   (past_ends)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls at random, except in the steady stretch
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 19);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // total envelope length under the current point count
  function automatic int unsigned envelope_length();
    int unsigned n;
    int unsigned total;
    n = cur_count;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    total = 0;
    for (int i = 0; i < n; i++) total += shadow_dur[i];
    return total;
  endfunction

  function automatic in_item_t mk_load(input int idx, input int lvl, input int dur);
    in_item_t it;
    it.cmd         = CMD_LOAD;
    it.point_index = idx[3:0];
    it.level       = lvl[15:0];
    it.duration    = dur[15:0];
    it.tick        = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_eval(input int unsigned tick);
    in_item_t it;
    it.cmd         = CMD_EVAL;
    it.point_index = 4'($urandom);
    it.level       = 16'($urandom);
    it.duration    = 16'($urandom);
    it.tick        = (tick > 65535) ? 16'hFFFF : tick[15:0];
    return it;
  endfunction

  // mostly loads into the active points and ticks inside the envelope
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned n;
    int unsigned total;
    int unsigned span;
    int          sel;
    n = (cur_count == 0) ? 1 : (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
    total = envelope_length();
    if ($urandom_range(99) < 30) begin
      it  = mk_load($urandom_range(15), $urandom_range(65535), $urandom_range(65535));
      if ($urandom_range(99) < 70) it.point_index = 4'($urandom_range(n - 1));
      sel = $urandom_range(99);
      if (sel < 10) it.level = 16'h0000;
      else if (sel < 20) it.level = 16'hFFFF;
      sel = $urandom_range(99);
      if (sel < 8) it.duration = 16'd0;
      else if (sel < 50) it.duration = 16'($urandom_range(1, 64));
      else if (sel < 90) it.duration = 16'($urandom_range(65, 4000));
    end else begin
      it   = mk_eval($urandom_range(65535));
      span = (total > 65536) ? 65536 : total;
      sel  = $urandom_range(99);
      if (total != 0) begin
        if (sel < 80) it.tick = 16'($urandom_range(span - 1));
        else if (sel < 87) it.tick = 16'(span - 1);
        else if (sel < 94) it.tick = (total > 65535) ? 16'hFFFF : 16'(total);
      end
    end
    return it;
  endfunction

  // one transaction on the in channel, then maybe a gap
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.cmd == CMD_LOAD) begin
      shadow_dur[it.point_index] = it.duration;
      load_count++;
    end else begin
      eval_count++;
    end
    if (!steady && $urandom_range(99) < 19) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
  endtask

  // hold the sender until every result is in and the block has settled
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_point_count(input logic [4:0] value);
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_count   = value;
    settings_count++;
  endtask

  // main sequence
  initial begin
    int unsigned total;
    logic [4:0]  count_val;
    logic [4:0]  phase_counts [PHASES];
    phase_counts = '{5'd1, 5'd16, 5'd17, 5'd2, 5'd0, 5'd0, 5'd8, 5'd0, 5'd5, 5'd0};
    for (int i = 0; i < MAX_POINTS; i++) shadow_dur[i] = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single point after reset: zero total length, then a full-length flat segment
    send_item(mk_load(0, 65535, 0));
    send_item(mk_eval(0));
    send_item(mk_load(0, 0, 65535));
    send_item(mk_eval(65534));
    send_item(mk_eval(65535));

    // full table: full-range rise, fast fall, zero-length segments, wrap to point 0
    set_point_count(5'd16);
    for (int i = 0; i < MAX_POINTS; i++) begin
      int lvl;
      int dur;
      lvl = $urandom_range(65535);
      dur = $urandom_range(1, 3000);
      case (i)
        0: begin lvl = 0; dur = 7; end
        1: begin lvl = 65535; dur = 3; end
        2: begin lvl = 0; dur = 0; end
        3: begin lvl = 16'hA5A5; dur = 100; end
        4: lvl = 16'hA5A5;
        9: dur = 0;
        15: begin lvl = 65535; dur = 5; end
        default: ;
      endcase
      send_item(mk_load(i, lvl, dur));
    end
    total = envelope_length();
    send_item(mk_eval(0));
    send_item(mk_eval(7));
    send_item(mk_eval(9));
    send_item(mk_eval(10));
    send_item(mk_eval(total - 1));
    send_item(mk_eval(total));
    send_item(mk_eval(65535));

    // count zero acts as one point
    set_point_count(5'd0);
    send_item(mk_eval(6));
    send_item(mk_eval(7));

    // count above the table saturates
    set_point_count(5'd31);
    send_item(mk_eval(envelope_length() - 1));

    // random phases under several point counts
    for (int p = 0; p < PHASES; p++) begin
      count_val = (p inside {4, 5, 7, 9}) ? 5'($urandom_range(31)) : phase_counts[p];
      steady = (p == 4);
      set_point_count(count_val);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 6 && k == PHASE_ITEMS / 2) drain_results();
        send_item(random_item());
      end
    end
    steady = 1'b0;

    drain_results();
    $display("covered %0d loads and %0d evaluates over %0d point count settings",
             load_count, eval_count, settings_count);
    $display("checked %0d results, %0d of them past the envelope end", results, past_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
